// File: hdl/bof_pkg.sv
`default_nettype none

package bof_pkg;

  // row store geometry
  localparam int MAX_LINE_WORDS = 64;
  localparam int IDX_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
  localparam int LEN_W = $clog2(MAX_LINE_WORDS + 1);

  // field widths
  localparam int PIX_W = 16;
  localparam int CFG_W = 7;
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one word of the row store: row above and row being outlined
  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] middle;
  } mem_word_t;

  // one result item
  typedef struct packed {
    logic [PIX_W-1:0] word;
    logic             last;
  } result_t;

  // results found by the two lanes for one accepted item
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/bof_lane.sv
`default_nettype none

module bof_lane (
  input  wire logic [bof_pkg::PIX_W-1:0] above,
  input  wire logic [bof_pkg::PIX_W-1:0] middle,
  input  wire logic [bof_pkg::PIX_W-1:0] below,
  input  wire logic [2:0]                left,
  input  wire logic [2:0]                right,
  output      logic [bof_pkg::PIX_W-1:0] outline
);
  import bof_pkg::*;

  logic [PIX_W+1:0] xa;
  logic [PIX_W+1:0] xm;
  logic [PIX_W+1:0] xb;

  // rows widened by the neighbor pixels left and right of the word
  assign xa = {left[2], above, right[2]};
  assign xm = {left[1], middle, right[1]};
  assign xb = {left[0], below, right[0]};

  // 3x3 dilation minus the pixel itself, one pixel per bit
  for (genvar i = 0; i < PIX_W; i++) begin : g_pix
    assign outline[i] = (xa[i] | xa[i+1] | xa[i+2] |
                         xb[i] | xb[i+1] | xb[i+2] |
                         xm[i] | xm[i+2]) & ~middle[i];
  end

endmodule

`default_nettype wire

// File: hdl/bof_line_mem.sv
`default_nettype none

module bof_line_mem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      we,
  input  wire logic [bof_pkg::IDX_W-1:0] waddr,
  input  wire bof_pkg::mem_word_t        wdata,
  input  wire logic [bof_pkg::IDX_W-1:0] raddr,
  output      bof_pkg::mem_word_t        rdata
);
  import bof_pkg::*;

  mem_word_t                 mem [MAX_LINE_WORDS];
  logic [MAX_LINE_WORDS-1:0] written;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // per-entry written flags, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // registered read with write-through on a same-address write
  always_ff @(posedge clk) begin
    if (rst) begin
      rdata <= '0;
    end else if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else if (written[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bof_merge.sv
`default_nettype none

module bof_merge (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bof_pkg::push_t            push,
  output      logic                      room,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [bof_pkg::PIX_W-1:0] outline_word,
  output      logic                      last_in_row
);
  import bof_pkg::*;

  result_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QCNT_W-1:0]  count;
  logic [QPTR_W-1:0]  b_addr;
  logic               pop;
  logic [QCNT_W-1:0]  n_push;

  assign pop    = out_valid && out_ready;
  assign n_push = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);
  assign b_addr = push.a_valid ? (tail + QPTR_W'(1)) : tail;

  // lane a result goes first, lane b result right behind it
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[tail] <= push.a;
    end
    if (push.b_valid) begin
      entries[b_addr] <= push.b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(n_push);
      count <= count + n_push - QCNT_W'(pop);
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
    end
  end

  // output side and space for a full pair of results
  assign out_valid    = (count != '0);
  assign outline_word = entries[head].word;
  assign last_in_row  = entries[head].last;
  assign room         = (count <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

`default_nettype wire

// File: hdl/bitmap_outline_filter.sv
`default_nettype none

// Streaming outline of a 1-bit-per-pixel image given as 16-pixel words in
// raster order, MSB leftmost. An outline pixel is set where the source pixel
// is clear and any of its eight neighbors is set; pixels outside the image
// are zero. Set line_words (1..64; 0 acts as 1, larger values as 64) while
// the block is idle, and mark every word of an image's first row with
// first_row. The outline of row r comes out while row r+1 streams in, one
// word behind; the last word of row r comes out with the last word of row
// r+1, and the final row of an image is never outlined. One word is taken
// per clock while the result queue has room; at the end of a row wider than
// one word the input pauses, because the single write port of the row store
// has two words to update. A four-entry result queue decouples the output
// from the input.
module bitmap_outline_filter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      line_words_we,
  input  wire logic [bof_pkg::CFG_W-1:0] line_words,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [bof_pkg::PIX_W-1:0] pixel_word,
  input  wire logic                      first_row,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [bof_pkg::PIX_W-1:0] outline_word,
  output      logic                      last_in_row
);
  import bof_pkg::*;

  // configuration and row state
  logic [CFG_W-1:0] line_len;
  logic [IDX_W-1:0] word_index;
  logic [IDX_W-1:0] word_index_next;
  logic             middle_valid;
  logic [PIX_W-1:0] held_below;
  logic [2:0]       left_carry;
  logic [PIX_W-1:0] prev_above;
  logic [PIX_W-1:0] prev_middle;

  // deferred second write at row end
  logic             pend;
  logic [IDX_W-1:0] pend_addr;
  mem_word_t        pend_data;

  // row store port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mem_word_t        mem_wdata;
  mem_word_t        rd;

  logic             accept;
  logic             room;
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] len;
  logic             last;
  logic             at_start;
  logic             mv_eff;
  logic [2:0]       left_after;
  logic [2:0]       right_bits;
  logic [PIX_W-1:0] lane_a_word;
  logic [PIX_W-1:0] lane_b_word;
  push_t            push;

  assign in_ready = room && !pend;
  assign accept   = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_len <= CFG_W'(1);
    end else if (line_words_we) begin
      line_len <= line_words;
    end
  end

  // clamped row length and end-of-row detection
  assign cfg_ext = CMP_W'(line_len);
  always_comb begin
    if (cfg_ext == '0) begin
      len = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_LINE_WORDS)) begin
      len = CMP_W'(MAX_LINE_WORDS);
    end else begin
      len = cfg_ext;
    end
  end

  assign at_start   = (word_index == '0);
  assign last       = (CMP_W'(word_index) + CMP_W'(1)) >= len;
  assign mv_eff     = (at_start && first_row) ? 1'b0 : middle_valid;
  assign left_after = at_start ? 3'b000 : {prev_above[0], prev_middle[0], held_below[0]};
  assign right_bits = {rd.above[PIX_W-1], rd.middle[PIX_W-1], pixel_word[PIX_W-1]};

  // lane a outlines the word left of the incoming one
  bof_lane u_lane_a (
    .above   (prev_above),
    .middle  (prev_middle),
    .below   (held_below),
    .left    (left_carry),
    .right   (right_bits),
    .outline (lane_a_word)
  );

  // lane b outlines the last word of the row, nothing to its right
  bof_lane u_lane_b (
    .above   (rd.above),
    .middle  (rd.middle),
    .below   (pixel_word),
    .left    (left_after),
    .right   (3'b000),
    .outline (lane_b_word)
  );

  // results handed to the merge queue
  always_comb begin
    push.a_valid = accept && !at_start && mv_eff;
    push.a.word  = lane_a_word;
    push.a.last  = 1'b0;
    push.b_valid = accept && last && mv_eff;
    push.b.word  = lane_b_word;
    push.b.last  = 1'b1;
  end

  bof_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outline_word (outline_word),
    .last_in_row  (last_in_row)
  );

  // row store write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_index;
    mem_wdata = '0;
    if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = pend_data;
    end else if (accept && !at_start) begin
      mem_we           = 1'b1;
      mem_waddr        = word_index - IDX_W'(1);
      mem_wdata.above  = mv_eff ? prev_middle : '0;
      mem_wdata.middle = held_below;
    end else if (accept && last) begin
      mem_we           = 1'b1;
      mem_waddr        = word_index;
      mem_wdata.above  = mv_eff ? rd.middle : '0;
      mem_wdata.middle = pixel_word;
    end
  end

  // position of the next incoming word, also the read address
  always_comb begin
    word_index_next = word_index;
    if (accept) begin
      word_index_next = last ? '0 : (word_index + IDX_W'(1));
    end
  end

  bof_line_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (word_index_next),
    .rdata (rd)
  );

  // deferred write of the last word when the row has more than one word
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept && last && !at_start;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_addr        <= word_index;
      pend_data.above  <= mv_eff ? rd.middle : '0;
      pend_data.middle <= pixel_word;
    end
  end

  // row state update per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= '0;
      middle_valid <= 1'b0;
      held_below   <= '0;
      left_carry   <= '0;
      prev_above   <= '0;
      prev_middle  <= '0;
    end else if (accept) begin
      word_index  <= word_index_next;
      prev_above  <= rd.above;
      prev_middle <= rd.middle;
      if (last) begin
        middle_valid <= 1'b1;
        held_below   <= '0;
        left_carry   <= '0;
      end else begin
        middle_valid <= mv_eff;
        held_below   <= pixel_word;
        left_carry   <= left_after;
      end
    end
  end

endmodule

`default_nettype wire
